// ----- rtl/wpg_pkg.sv -----
package wpg_pkg;

    localparam int MAX_WAYPOINTS_DEF = 64;

    // field widths
    localparam int POS_W   = 21;
    localparam int DIFF_W  = 22;
    localparam int HEAD_W  = 15;
    localparam int YOKE_W  = 15;
    localparam int TGT_W   = 7;
    localparam int RAD_W   = 20;
    localparam int DWRAP_W = 17;

    // input kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_LOAD   = 2'd2;
    localparam logic [1:0] KIND_SAMPLE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OFF  = 2'd0;
    localparam logic [1:0] STAT_ON   = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    // register indexes
    localparam logic [0:0] CFG_HITBOX = 1'b0;
    localparam logic [0:0] CFG_COUNT  = 1'b1;

    localparam logic [RAD_W-1:0] HITBOX_RST = 20'd53352;

    // CORDIC
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int CX_W         = 25;
    localparam int Z_W          = 26;
    localparam int ATAN_W       = 22;
    localparam logic signed [Z_W-1:0] DEG_Q16_180 = 26'sd11796480;
    localparam logic signed [Z_W-1:0] DEG_Q16_360 = 26'sd23592960;
    localparam int ROUND_SHIFT = 10;
    localparam logic signed [Z_W-1:0] ROUND_HALF = 26'sd512;

    // heading arithmetic, 1/64 degree
    localparam logic [HEAD_W-1:0] HEAD_360 = 15'd23040;
    localparam logic signed [DWRAP_W-1:0] HEAD_180_S = 17'sd11520;
    localparam logic signed [DWRAP_W-1:0] HEAD_360_S = 17'sd23040;

    // yoke = round(|d| * 125 / 72), divide via reciprocal
    localparam int N_W = 21;
    localparam logic [N_W-1:0] YOKE_GAIN  = 21'd125;
    localparam logic [N_W-1:0] YOKE_BIAS  = 21'd36;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd7456541;
    localparam logic [YOKE_W-1:0] YOKE_MAX = 15'd10000;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/wpg_cordic.sv -----
module wpg_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [wpg_pkg::DIFF_W-1:0]    i_vx,
    input  logic signed [wpg_pkg::DIFF_W-1:0]    i_vy,
    output logic                                 o_done,
    output logic        [wpg_pkg::HEAD_W-1:0]    o_bearing
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ITER = 2'd1;
    localparam logic [1:0] C_WRAP = 2'd2;
    localparam logic [1:0] C_RND  = 2'd3;

    logic [1:0]                          r_cs;
    logic [wpg_pkg::STEP_W-1:0]          r_step;
    logic                                r_done;
    logic signed [wpg_pkg::CX_W-1:0]     r_x;
    logic signed [wpg_pkg::CX_W-1:0]     r_y;
    logic signed [wpg_pkg::Z_W-1:0]      r_z;
    logic [wpg_pkg::HEAD_W-1:0]          r_bear;

    logic signed [wpg_pkg::CX_W-1:0]     x0;
    logic signed [wpg_pkg::CX_W-1:0]     y0;
    logic signed [wpg_pkg::CX_W-1:0]     xs;
    logic signed [wpg_pkg::CX_W-1:0]     ys;
    logic signed [wpg_pkg::Z_W-1:0]      at;
    logic signed [wpg_pkg::Z_W-1:0]      zsum;
    logic [wpg_pkg::HEAD_W-1:0]          tq;
    logic [wpg_pkg::HEAD_W-1:0]          n_bear;
    logic                                last_step;

    assign x0        = wpg_pkg::CX_W'(i_vx);
    assign y0        = wpg_pkg::CX_W'(i_vy);
    assign xs        = r_x >>> r_step;
    assign ys        = r_y >>> r_step;
    assign at        = signed'(wpg_pkg::Z_W'(wpg_pkg::atan_q16(r_step)));
    assign zsum      = r_z + wpg_pkg::ROUND_HALF;
    assign tq        = zsum[wpg_pkg::ROUND_SHIFT +: wpg_pkg::HEAD_W];
    assign n_bear    = (tq >= wpg_pkg::HEAD_360) ? tq - wpg_pkg::HEAD_360 : tq;
    assign last_step = (r_step == wpg_pkg::STEP_W'(wpg_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= C_IDLE;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cs == C_RND);
            unique case (r_cs)
                C_IDLE: begin
                    r_step <= '0;
                    if (i_start) begin
                        r_cs <= (i_vx == '0 && i_vy == '0) ? C_WRAP : C_ITER;
                    end
                end
                C_ITER: begin
                    r_step <= r_step + 1'b1;
                    if (last_step) begin
                        r_cs <= C_WRAP;
                    end
                end
                C_WRAP:  r_cs <= C_RND;
                C_RND:   r_cs <= C_IDLE;
                default: r_cs <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_cs)
            C_IDLE: begin
                if (i_start) begin
                    if (i_vx == '0 && i_vy == '0) begin
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                    end else if (i_vx < 0) begin
                        r_x <= -x0;
                        r_y <= -y0;
                        r_z <= wpg_pkg::DEG_Q16_180;
                    end else begin
                        r_x <= x0;
                        r_y <= y0;
                        r_z <= '0;
                    end
                end
            end
            C_ITER: begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
            end
            C_WRAP: begin
                if (r_z < 0) begin
                    r_z <= r_z + wpg_pkg::DEG_Q16_360;
                end
            end
            C_RND:   r_bear <= n_bear;
            default: r_bear <= r_bear;
        endcase
    end

    assign o_done    = r_done;
    assign o_bearing = r_bear;

endmodule

// ----- rtl/waypoint_heading_guidance_top.sv -----
// Waypoint heading guidance. Beats on the slave stream are start, stop, waypoint load or
// aircraft sample (tuser); every beat yields exactly one result beat with status, yoke
// command and target index. Start, stop, load and inactive samples go straight to the
// result stage. An active sample reads the waypoint memory and runs the 20-step iterative
// CORDIC atan2; a capture of any but the last waypoint adds a second waypoint read, and
// the iterations are skipped when the aircraft sits on the waypoint. One item is processed
// at a time; the result register lets the next beat in while a result waits.
// Waypoints are held in a MAX_WAYPOINTS-deep memory that must be loaded before use.
// Configuration writes must go in while idle only; the block itself does not enforce this.
module waypoint_heading_guidance_top #(
    parameter int MAX_WAYPOINTS = wpg_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // slot[5:0], pos_x[26:6], pos_y[47:27], heading[62:48]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], yoke[16:2], target_index[23:17]
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int MW = 2 * wpg_pkg::POS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_CORD = 4'd3;
    localparam logic [3:0] S_MAG  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SAT  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]                          r_state;
    logic                                r_engaged;
    logic                                r_complete;
    logic [wpg_pkg::TGT_W-1:0]           r_target;
    logic                                r_second;
    logic                                r_m_valid;
    logic [wpg_pkg::RAD_W-1:0]           r_radius;
    logic [wpg_pkg::TGT_W-1:0]           r_wcount;

    logic [MW-1:0]                       r_wp_mem [MAX_WAYPOINTS];
    logic [MW-1:0]                       r_rd_data;

    logic signed [wpg_pkg::POS_W-1:0]    r_px;
    logic signed [wpg_pkg::POS_W-1:0]    r_py;
    logic [wpg_pkg::HEAD_W-1:0]          r_head;
    logic signed [wpg_pkg::YOKE_W-1:0]   r_yoke;
    logic signed [wpg_pkg::YOKE_W-1:0]   r_d;
    logic [wpg_pkg::N_W-1:0]             r_n;
    logic [wpg_pkg::YOKE_W-1:0]          r_q;
    logic [23:0]                         r_m_data;

    logic                                accept;
    logic [1:0]                          in_kind;
    logic [5:0]                          in_slot;
    logic signed [wpg_pkg::POS_W-1:0]    in_px;
    logic signed [wpg_pkg::POS_W-1:0]    in_py;
    logic [wpg_pkg::HEAD_W-1:0]          in_head;

    logic [wpg_pkg::TGT_W-1:0]           cnt;
    logic [wpg_pkg::TGT_W-1:0]           tgt_next;
    logic                                live;
    logic                                wr_en;
    logic                                rd_en;
    logic [AW-1:0]                       rd_addr;
    logic signed [wpg_pkg::POS_W-1:0]    mem_x;
    logic signed [wpg_pkg::POS_W-1:0]    mem_y;
    logic signed [wpg_pkg::DIFF_W-1:0]   dx;
    logic signed [wpg_pkg::DIFF_W-1:0]   dy;
    logic [wpg_pkg::DIFF_W-1:0]          adx;
    logic [wpg_pkg::DIFF_W-1:0]          ady;
    logic                                hit;
    logic signed [wpg_pkg::DIFF_W-1:0]   vx;
    logic signed [wpg_pkg::DIFF_W-1:0]   vy;
    logic                                c_start;
    logic                                c_done;
    logic [wpg_pkg::HEAD_W-1:0]          c_bear;
    logic signed [wpg_pkg::DWRAP_W-1:0]  d_raw;
    logic signed [wpg_pkg::DWRAP_W-1:0]  d_wrap;
    logic signed [wpg_pkg::YOKE_W-1:0]   d_abs;
    logic [wpg_pkg::N_W-1:0]             n_n;
    logic [wpg_pkg::N_W+wpg_pkg::RECIP_W-1:0] prod;
    logic [wpg_pkg::YOKE_W-1:0]          q_sat;
    logic [1:0]                          status;
    logic                                out_free;

    assign in_kind = s_axis_tuser;
    assign in_slot = s_axis_tdata[5:0];
    assign in_px   = signed'(s_axis_tdata[26:6]);
    assign in_py   = signed'(s_axis_tdata[47:27]);
    assign in_head = s_axis_tdata[62:48];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        if (32'(r_wcount) < MAX_WAYPOINTS) begin
            cnt = r_wcount;
        end else begin
            cnt = wpg_pkg::TGT_W'(MAX_WAYPOINTS);
        end
    end

    assign tgt_next = r_target + 1'b1;
    assign live     = r_engaged && !r_complete && (cnt != '0);

    // waypoint memory
    assign mem_x = signed'(r_rd_data[wpg_pkg::POS_W-1:0]);
    assign mem_y = signed'(r_rd_data[MW-1:wpg_pkg::POS_W]);
    assign wr_en = accept && (in_kind == wpg_pkg::KIND_LOAD) && (32'(in_slot) < MAX_WAYPOINTS);

    always_comb begin
        if (r_state == S_CHK) begin
            rd_en   = !r_second && hit && (tgt_next < cnt);
            rd_addr = AW'(tgt_next);
        end else begin
            rd_en   = accept && (in_kind == wpg_pkg::KIND_SAMPLE) && live && (r_target < cnt);
            rd_addr = AW'(r_target);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wp_mem[AW'(in_slot)] <= {in_py, in_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_wp_mem[rd_addr];
        end
    end

    // capture box test
    assign dx    = wpg_pkg::DIFF_W'(r_px) - wpg_pkg::DIFF_W'(mem_x);
    assign dy    = wpg_pkg::DIFF_W'(r_py) - wpg_pkg::DIFF_W'(mem_y);
    assign adx   = unsigned'(dx[wpg_pkg::DIFF_W-1] ? -dx : dx);
    assign ady   = unsigned'(dy[wpg_pkg::DIFF_W-1] ? -dy : dy);
    assign hit   = (adx <= {2'b00, r_radius}) && (ady <= {2'b00, r_radius});

    // bearing vector: x = ay - wy, y = wx - ax
    assign vx      = wpg_pkg::DIFF_W'(r_py) - wpg_pkg::DIFF_W'(mem_y);
    assign vy      = wpg_pkg::DIFF_W'(mem_x) - wpg_pkg::DIFF_W'(r_px);
    assign c_start = (r_state == S_CHK) && (r_second || !hit);

    wpg_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (c_start),
        .i_vx      (vx),
        .i_vy      (vy),
        .o_done    (c_done),
        .o_bearing (c_bear)
    );

    // heading error wrapped to (-180, 180]
    assign d_raw = signed'({2'b00, c_bear}) - signed'({2'b00, r_head});
    always_comb begin
        if (d_raw > wpg_pkg::HEAD_180_S) begin
            d_wrap = d_raw - wpg_pkg::HEAD_360_S;
        end else if (d_raw <= -wpg_pkg::HEAD_180_S) begin
            d_wrap = d_raw + wpg_pkg::HEAD_360_S;
        end else begin
            d_wrap = d_raw;
        end
    end

    assign d_abs = r_d[wpg_pkg::YOKE_W-1] ? -r_d : r_d;
    assign n_n   = wpg_pkg::N_W'(unsigned'(d_abs)) * wpg_pkg::YOKE_GAIN + wpg_pkg::YOKE_BIAS;
    assign prod  = (wpg_pkg::N_W+wpg_pkg::RECIP_W)'(r_n)
                 * (wpg_pkg::N_W+wpg_pkg::RECIP_W)'(wpg_pkg::RECIP_MUL);
    assign q_sat = (r_q > wpg_pkg::YOKE_MAX) ? wpg_pkg::YOKE_MAX : r_q;

    assign status = r_complete ? wpg_pkg::STAT_DONE
                  : (r_engaged ? wpg_pkg::STAT_ON : wpg_pkg::STAT_OFF);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_engaged  <= 1'b0;
            r_complete <= 1'b0;
            r_target   <= '0;
            r_second   <= 1'b0;
            r_m_valid  <= 1'b0;
            r_radius   <= wpg_pkg::HITBOX_RST;
            r_wcount   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wpg_pkg::CFG_HITBOX: r_radius <= i_cfg_data;
                    wpg_pkg::CFG_COUNT:  r_wcount <= i_cfg_data[wpg_pkg::TGT_W-1:0];
                    default:             r_radius <= r_radius;
                endcase
            end

            if (r_state == S_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_FIN;
                        unique case (in_kind)
                            wpg_pkg::KIND_START: begin
                                r_engaged  <= 1'b1;
                                r_complete <= 1'b0;
                                r_target   <= '0;
                            end
                            wpg_pkg::KIND_STOP: begin
                                r_engaged  <= 1'b0;
                                r_complete <= 1'b1;
                                r_target   <= '0;
                            end
                            wpg_pkg::KIND_SAMPLE: begin
                                if (live) begin
                                    if (r_target >= cnt) begin
                                        r_complete <= 1'b1;
                                        r_engaged  <= 1'b0;
                                    end else begin
                                        r_second <= 1'b0;
                                        r_state  <= S_RD;
                                    end
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (!r_second && hit) begin
                        r_target <= tgt_next;
                        if (tgt_next >= cnt) begin
                            r_complete <= 1'b1;
                            r_engaged  <= 1'b0;
                            r_state    <= S_FIN;
                        end else begin
                            r_second <= 1'b1;
                            r_state  <= S_RD;
                        end
                    end else begin
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (c_done) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: r_state <= S_DIV;
                S_DIV: r_state <= S_SAT;
                S_SAT: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= in_px;
            r_py   <= in_py;
            r_head <= in_head;
            r_yoke <= '0;
        end
        if (r_state == S_CORD && c_done) begin
            r_d <= wpg_pkg::YOKE_W'(d_wrap);
        end
        if (r_state == S_MAG) begin
            r_n <= n_n;
        end
        if (r_state == S_DIV) begin
            r_q <= prod[wpg_pkg::RECIP_SHIFT +: wpg_pkg::YOKE_W];
        end
        if (r_state == S_SAT) begin
            r_yoke <= r_d[wpg_pkg::YOKE_W-1] ? -signed'(q_sat) : signed'(q_sat);
        end
        if (r_state == S_FIN && out_free) begin
            r_m_data <= {r_target, r_yoke, status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_engaged && r_complete))
        else $error("engaged and complete both set");

    a_start_engages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (in_kind == wpg_pkg::KIND_START) |=>
            r_engaged && !r_complete && (r_target == '0))
        else $error("start beat did not engage");

    a_cordic_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_CORD))
        else $error("bearing finished outside bearing wait");

    a_yoke_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[16:2]) <= $signed(wpg_pkg::YOKE_MAX))
                       && ($signed(m_axis_tdata[16:2]) >= -$signed(wpg_pkg::YOKE_MAX)))
        else $error("yoke beyond saturation");

endmodule

// ----- tb/tb_waypoint_heading_guidance_top.sv -----
module tb_waypoint_heading_guidance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TABLE_DEPTH   = 64;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     RADIUS_MAX    = 1048575;
    localparam longint POS_HI        = 1048575;
    localparam longint POS_LO        = -1048576;
    localparam longint ANG_HALF_TURN = 11796480;
    localparam longint ANG_TURN      = 23592960;
    localparam longint HDG_TURN      = 23040;
    localparam longint HDG_HALF      = 11520;
    localparam longint YOKE_LIMIT    = 10000;
    localparam logic signed [20:0] XY_MAX = 21'h0FFFFF;
    localparam logic signed [20:0] XY_MIN = 21'h100000;
    localparam longint ATAN_DEG_Q16 [0:19] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    // lowest bits first on the bus: status, yoke, target
    typedef struct packed {
        logic [6:0]         target;
        logic signed [14:0] yoke;
        logic [1:0]         status;
    } t_steer;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_idx     = '0;
    logic [19:0] i_cfg_data    = '0;

    waypoint_heading_guidance_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // guidance state as the block should hold it
    int     mdl_radius  = 53352;
    int     mdl_count   = 0;
    bit     mdl_engaged = 1'b0;
    bit     mdl_done    = 1'b0;
    int     mdl_target  = 0;
    longint wp_x [TABLE_DEPTH];
    longint wp_y [TABLE_DEPTH];
    bit     wp_written [TABLE_DEPTH];

    t_steer steer_due_q [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int beat_cnt      = 0;
    int result_cnt    = 0;
    int capture_cnt   = 0;
    int complete_cnt  = 0;
    int err_cnt       = 0;
    int stall_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [20:0] clamp_pos(input longint v);
        longint c;
        c = v;
        if (c > POS_HI) c = POS_HI;
        if (c < POS_LO) c = POS_LO;
        return c[20:0];
    endfunction

    function automatic int mission_len();
        return (mdl_count < TABLE_DEPTH) ? mdl_count : TABLE_DEPTH;
    endfunction

    // bearing from aircraft to waypoint, 1/64 degree
    function automatic longint bearing_q6(input longint ax, input longint ay,
                                          input longint wx, input longint wy);
        longint x, y, z, xs, ys;
        int     i;
        x = ay - wy;
        y = wx - ax;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANG_HALF_TURN;
        end
        for (i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG_Q16[i];
            end
        end
        while (z < 0) z = z + ANG_TURN;
        while (z >= ANG_TURN) z = z - ANG_TURN;
        z = (z + 512) >>> 10;
        if (z >= HDG_TURN) z = z - HDG_TURN;
        return z;
    endfunction

    function automatic longint yoke_cmd(input longint brg, input longint hdg);
        longint d, q;
        d = brg - hdg;
        while (d > HDG_HALF) d = d - HDG_TURN;
        while (d <= -HDG_HALF) d = d + HDG_TURN;
        q = (mag64(d) * 125 + 36) / 72;
        if (q > YOKE_LIMIT) q = YOKE_LIMIT;
        return (d < 0) ? -q : q;
    endfunction

    function automatic t_steer steer_predict(input logic [1:0] kind, input logic [5:0] slot,
                                             input logic signed [20:0] px,
                                             input logic signed [20:0] py,
                                             input logic [14:0] hdg);
        t_steer res;
        longint ax, ay, tx, ty, yk;
        int     cnt;
        ax  = px;
        ay  = py;
        yk  = 0;
        cnt = mission_len();
        case (kind)
            wpg_pkg::KIND_START: begin
                mdl_engaged = 1'b1;
                mdl_done    = 1'b0;
                mdl_target  = 0;
            end
            wpg_pkg::KIND_STOP: begin
                mdl_engaged = 1'b0;
                mdl_done    = 1'b1;
                mdl_target  = 0;
            end
            wpg_pkg::KIND_LOAD: begin
                wp_x[slot]       = ax;
                wp_y[slot]       = ay;
                wp_written[slot] = 1'b1;
            end
            default: begin
                if (mdl_engaged && !mdl_done && cnt != 0) begin
                    if (mdl_target < cnt) begin
                        tx = wp_x[mdl_target];
                        ty = wp_y[mdl_target];
                        if (mag64(ax - tx) <= mdl_radius && mag64(ay - ty) <= mdl_radius) begin
                            mdl_target++;
                            capture_cnt++;
                        end
                    end
                    if (mdl_target >= cnt) begin
                        mdl_done    = 1'b1;
                        mdl_engaged = 1'b0;
                        complete_cnt++;
                    end else begin
                        yk = yoke_cmd(bearing_q6(ax, ay, wp_x[mdl_target], wp_y[mdl_target]),
                                      longint'(hdg));
                    end
                end
            end
        endcase
        res.status = mdl_done ? wpg_pkg::STAT_DONE
                   : (mdl_engaged ? wpg_pkg::STAT_ON : wpg_pkg::STAT_OFF);
        res.yoke   = yk[14:0];
        res.target = mdl_target[6:0];
        return res;
    endfunction

    // a sample must never read a waypoint entry that was never loaded
    function automatic bit table_ready(output logic [5:0] missing);
        int cnt;
        cnt     = mission_len();
        missing = '0;
        if (!mdl_engaged || mdl_done || cnt == 0 || mdl_target >= cnt) return 1'b1;
        if (!wp_written[mdl_target]) begin
            missing = mdl_target[5:0];
            return 1'b0;
        end
        if (mdl_target + 1 < cnt && !wp_written[mdl_target + 1]) begin
            missing = 6'(mdl_target + 1);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [20:0] rand_pos();
        int t;
        if ($urandom_range(0, 99) < 30) begin
            t = $urandom();
        end else begin
            t = $urandom_range(0, 200000);
            t = t - 100000;
        end
        return t[20:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < 40)
            $display("[%0t] mismatch on result %0d: %s", $realtime, result_cnt, what);
        err_cnt++;
    endtask

    task automatic queue_due(input t_steer r);
        steer_due_q.insert(steer_due_q.size(), r);
    endtask

    task automatic send_beat(input logic [1:0] kind, input logic [5:0] slot,
                             input logic signed [20:0] px, input logic signed [20:0] py,
                             input logic [14:0] hdg);
        logic [1:0] k;
        logic [5:0] s;
        logic [5:0] missing;
        k = kind;
        s = slot;
        if (k == wpg_pkg::KIND_SAMPLE && !table_ready(missing)) begin
            k = wpg_pkg::KIND_LOAD;
            s = missing;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {1'b0, hdg, py, px, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_due(steer_predict(k, s, px, py, hdg));
        beat_cnt++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (steer_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int rad, input int cnt);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wpg_pkg::CFG_HITBOX;
        i_cfg_data <= rad[19:0];
        @(posedge i_clk);
        i_cfg_idx  <= wpg_pkg::CFG_COUNT;
        i_cfg_data <= 20'(cnt);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mdl_radius = rad;
        mdl_count  = cnt;
    endtask

    task automatic send_sample();
        int               cnt, r, m;
        longint           ox, oy, tx, ty;
        logic signed [20:0] px, py;
        logic [14:0]      hdg;
        cnt = mission_len();
        r   = mdl_radius;
        m   = $urandom_range(0, 99);
        px  = rand_pos();
        py  = rand_pos();
        if (mdl_engaged && !mdl_done && mdl_target < cnt && wp_written[mdl_target]) begin
            tx = wp_x[mdl_target];
            ty = wp_y[mdl_target];
            ox = longint'($urandom_range(0, 2 * r));
            ox = ox - r;
            oy = longint'($urandom_range(0, 2 * r));
            oy = oy - r;
            if (m < 35) begin
                px = clamp_pos(tx + ox);
                py = clamp_pos(ty + oy);
            end else if (m < 45) begin
                px = tx[20:0];
                py = ty[20:0];
            end else if (m < 55) begin
                // just outside the box on one axis
                px = clamp_pos(tx + ((m % 2 == 1) ? r + 1 : -r - 1));
                py = clamp_pos(ty + oy);
            end
        end
        if ($urandom_range(0, 99) < 88)
            hdg = 15'($urandom_range(0, 23039));
        else
            hdg = 15'($urandom_range(23040, 32767));
        send_beat(wpg_pkg::KIND_SAMPLE, 6'($urandom_range(0, 63)), px, py, hdg);
    endtask

    task automatic run_mission(input int n_items, input bit full_table);
        int rad, cnt, k, r;
        r = $urandom_range(0, 99);
        if (r < 10)      rad = 0;
        else if (r < 20) rad = RADIUS_MAX;
        else if (r < 55) rad = $urandom_range(10000, 200000);
        else             rad = $urandom_range(0, RADIUS_MAX);
        r = $urandom_range(0, 99);
        if (r < 10)      cnt = 0;
        else if (r < 16) cnt = TABLE_DEPTH;
        else if (r < 30) cnt = 1;
        else             cnt = $urandom_range(2, 6);
        if (full_table) begin
            rad = RADIUS_MAX;
            cnt = TABLE_DEPTH;
        end
        wait_idle();
        configure(rad, cnt);
        for (k = 0; k < cnt; k++)
            send_beat(wpg_pkg::KIND_LOAD, k[5:0], rand_pos(), rand_pos(), 15'($urandom()));
        // sometimes carry on from the last mission without a fresh start
        if (full_table || $urandom_range(0, 99) < 85)
            send_beat(wpg_pkg::KIND_START, 6'($urandom()), rand_pos(), rand_pos(),
                      15'($urandom()));
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 74)
                send_sample();
            else if (r < 84)
                send_beat(wpg_pkg::KIND_LOAD, 6'($urandom()), rand_pos(), rand_pos(),
                          15'($urandom()));
            else if (r < 89)
                send_beat(wpg_pkg::KIND_START, 6'($urandom()), rand_pos(), rand_pos(),
                          15'($urandom()));
            else if (r < 93)
                send_beat(wpg_pkg::KIND_STOP, 6'($urandom()), rand_pos(), rand_pos(),
                          15'($urandom()));
            else
                send_beat(2'($urandom()), 6'($urandom()), 21'($urandom()), 21'($urandom()),
                          15'($urandom()));
        end
    endtask

    task automatic test_reset_modes();
        src_idle_pct  = 24;
        sink_idle_pct = 67;
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, 21'sd0, 21'sd0, 15'd0);
        send_beat(wpg_pkg::KIND_STOP, 6'h3F, XY_MAX, XY_MIN, 15'h7FFF);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, XY_MAX, XY_MAX, 15'd100);
        send_beat(wpg_pkg::KIND_START, 6'd0, XY_MIN, XY_MAX, 15'd0);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd5, 21'sd1234, -21'sd777, 15'd23039);
    endtask

    task automatic test_extremes_and_capture();
        send_beat(wpg_pkg::KIND_LOAD, 6'd0, XY_MAX, XY_MAX, 15'd0);
        send_beat(wpg_pkg::KIND_LOAD, 6'd1, XY_MIN, XY_MIN, 15'd0);
        send_beat(wpg_pkg::KIND_LOAD, 6'd2, XY_MIN, XY_MIN, 15'h7FFF);
        send_beat(wpg_pkg::KIND_LOAD, 6'h3F, XY_MIN, XY_MAX, 15'h7FFF);
        wait_idle();
        configure(0, 3);
        send_beat(wpg_pkg::KIND_START, 6'd0, 21'sd0, 21'sd0, 15'd0);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, 21'sd0, 21'sd0, 15'd23039);
        // exact hit with a zero-size box, then the heading field at its top
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, XY_MAX, XY_MAX, 15'h7FFF);
        // capture onto a waypoint at the same spot: zero bearing vector
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, XY_MIN, XY_MIN, 15'd0);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, XY_MIN, XY_MIN, 15'd11520);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, 21'sd0, 21'sd0, 15'd0);
    endtask

    task automatic test_count_lowered();
        wait_idle();
        configure(RADIUS_MAX, 3);
        send_beat(wpg_pkg::KIND_START, 6'd0, 21'sd0, 21'sd0, 15'd0);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, 21'sd0, 21'sd0, 15'd5760);
        wait_idle();
        configure(53352, 1);
        send_beat(wpg_pkg::KIND_SAMPLE, 6'd0, 21'sd0, 21'sd0, 15'd5760);
    endtask

    task automatic test_guidance_sequences(input int src_pct, input int sink_pct,
                                           input int n_items, input bit with_full);
        int  first_beat;
        bit  full;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first_beat    = beat_cnt;
        full          = with_full;
        while (beat_cnt - first_beat < n_items) begin
            run_mission($urandom_range(12, 36), full);
            full = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_steer want;
        t_steer got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (steer_due_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = steer_due_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.yoke !== want.yoke)
                    report_mismatch($sformatf("yoke %0d, want %0d", got.yoke, want.yoke));
                if (got.target !== want.target)
                    report_mismatch($sformatf("target %0d, want %0d", got.target, want.target));
            end
            result_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     stall_cycles, steer_due_q.size());
            $display("tb_waypoint_heading_guidance_top: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_modes();
        test_extremes_and_capture();
        test_count_lowered();
        test_guidance_sequences(24, 67, 165, 1'b0);
        test_guidance_sequences(67, 24, 165, 1'b0);
        test_guidance_sequences(0, 0, 165, 1'b1);
        wait_idle();
        $display("%0d beats sent, %0d results checked, %0d captures, %0d missions completed",
                 beat_cnt, result_cnt, capture_cnt, complete_cnt);
        $display("box sizes 0 to max, counts 0 to full table, three idle mixes on both sides");
        if (err_cnt == 0) begin
            $display("tb_waypoint_heading_guidance_top: PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("tb_waypoint_heading_guidance_top: FAIL");
        end
        $finish;
    end

endmodule
